>>> rtl/scan_weighted_centroid_angle_defines.svh
// Assertion macros shared by the weighted centroid bearing RTL.
// Included by the modules that carry concurrent checks; needs no other file.
`ifndef SCAN_WEIGHTED_CENTROID_ANGLE_DEFINES_SVH
`define SCAN_WEIGHTED_CENTROID_ANGLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWCA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swca: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SWCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swca: next-cycle check failed");

`endif

>>> rtl/swca_pkg.sv
// Types and constants of the weighted centroid bearing block.
// Used by swca_div and scan_weighted_centroid_angle; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package swca_pkg;

   localparam int DEF_MAX_SAMPLES = 1024;

   // Fixed widths of the accumulators and the divider.
   localparam int WIS_W     = 48;
   localparam int WS_W      = 38;
   localparam int W_W       = 28;
   localparam int NUM_W     = 72;
   localparam int DEN_W     = 46;
   localparam int QUOT_BITS = 23;
   localparam int QUOT_W    = QUOT_BITS + 1;
   localparam int DIV_CNT_W = $clog2(QUOT_BITS);

   // Shared multiplier operand widths.
   localparam int MUL_A_W = 28;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [QUOT_W-1:0] OFFSET_CAP = QUOT_W'(1) << QUOT_BITS;

   localparam logic signed [25:0] SUM_LIMIT   = 26'sd1000000;
   localparam logic signed [20:0] BEARING_MAX = 21'sd1000000;
   localparam logic signed [20:0] BEARING_MIN = -21'sd1000000;

   // Configuration register indexes.
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_RANGE_MIN  = 3'd0;
   localparam logic [2:0] REG_RANGE_MAX  = 3'd1;
   localparam logic [2:0] REG_GAIN       = 3'd2;
   localparam logic [2:0] REG_START      = 3'd3;
   localparam logic [2:0] REG_ANGLE_STEP = 3'd4;

   localparam logic [15:0] RANGE_MAX_RESET = 16'hFFFF;
   localparam logic [9:0]  GAIN_RESET      = 10'd384;

   typedef struct packed {
      logic [15:0]        range_mm;
      logic               has_return;
      logic signed [19:0] joint_angle;
      logic               last_sample;
   } req_data_type;

   typedef struct packed {
      logic signed [20:0] bearing;
      logic               zero_weight;
   } rsp_data_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> rtl/swca_div.sv
// Saturating restoring divider for the centroid offset: num / den capped at 2^23.
// Uses swca_pkg and the assertion macros of scan_weighted_centroid_angle_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "scan_weighted_centroid_angle_defines.svh"

module swca_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [swca_pkg::NUM_W-1:0]      num,
   input  wire logic [swca_pkg::DEN_W-1:0]      den,
   output swca_pkg::div_status_type             stat,
   output logic      [swca_pkg::QUOT_W-1:0]     quot
);

   localparam int NW = swca_pkg::NUM_W;
   localparam int DW = swca_pkg::DEN_W;
   localparam int QB = swca_pkg::QUOT_BITS;
   localparam int HW = NW - QB;

   logic                            busy_ff, busy_in;
   logic                            chk_ff, chk_in;
   logic                            done_ff, done_in;
   logic [swca_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NW-1:0]                   num_ff, num_in;
   logic [DW-1:0]                   den_ff, den_in;
   logic [DW-1:0]                   rem_ff, rem_in;
   logic [swca_pkg::QUOT_W-1:0]     q_ff, q_in;
   logic [DW:0]                     trial;
   logic [DW:0]                     diff;

   assign trial = {rem_ff, num_ff[QB-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      chk_in  = chk_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         chk_in  = 1'b1;
         num_in  = num;
         den_in  = den;
      end else if (busy_ff && chk_ff) begin
         // The quotient reaches the cap exactly when num / 2^23 >= den.
         if (num_ff[NW-1:QB] >= HW'(den_ff)) begin
            q_in    = swca_pkg::OFFSET_CAP;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in = num_ff[QB+DW-1:QB];
            q_in   = '0;
            cnt_in = '0;
            chk_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DW-1:0];
            q_in   = {q_ff[swca_pkg::QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            q_in   = {q_ff[swca_pkg::QUOT_W-2:0], 1'b0};
         end
         num_in = {num_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == swca_pkg::DIV_CNT_W'(QB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         chk_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         chk_ff  <= chk_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;

   `SWCA_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && chk_ff)
   `SWCA_ASSERT_NOW(a_quot_capped, clock, reset, done_ff, q_ff <= swca_pkg::OFFSET_CAP)
   `SWCA_ASSERT_NOW(a_rem_below_den, clock, reset, busy_ff && !chk_ff, rem_ff < den_ff)

endmodule

`default_nettype wire

>>> rtl/scan_weighted_centroid_angle.sv
// Top level of the weighted centroid bearing block: sequencer, accumulators,
// shared multiplier and registers. Uses swca_pkg, swca_div and the macro header.
//
//   Channel  Direction  Handshake                 Payload
//   req_     in         req_valid / req_stall     swca_pkg::req_data_type
//   rsp_     out        rsp_valid / rsp_stall     swca_pkg::rsp_data_type
//   csr_     in/out     APB psel/penable/pready   32-bit registers at 4*index
//
// A sample passes through accept, weight, index product and accumulate, and no
// new sample is taken before the sequencer is back in idle. A sample marked last
// then goes through the magnitudes, the sum of the three partial products of the
// numerator, the divider start, the divider (a cap check, one quotient bit per
// cycle for 23 bits, handing the quotient back) and the load of the result.
// A capped quotient skips the quotient bits; a zero weight sum goes straight
// from the magnitudes to the load.
// Reset is synchronous and active high; it clears the scan sums and control.
// A waiting result sits in the output register and does not stop new samples;
// only the next result waits for it to be taken.
`timescale 1ns / 1ps
`default_nettype none

`include "scan_weighted_centroid_angle_defines.svh"

module scan_weighted_centroid_angle #(
   parameter int MAX_SAMPLES = swca_pkg::DEF_MAX_SAMPLES
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Sample input.
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire swca_pkg::req_data_type             req_data,
   // Bearing output.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output swca_pkg::rsp_data_type                  rsp_data,
   // Register port.
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [swca_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);

   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam int AW    = swca_pkg::MUL_A_W;
   localparam int BW    = swca_pkg::MUL_B_W;
   localparam int PW    = swca_pkg::MUL_P_W;
   localparam int WW    = swca_pkg::W_W;

   // One-hot sequencer states.
   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_WGT  = 9'b000000010,
      ST_PROD = 9'b000000100,
      ST_ACC  = 9'b000001000,
      ST_MAG  = 9'b000010000,
      ST_PP   = 9'b000100000,
      ST_DGO  = 9'b001000000,
      ST_DIV  = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0]        range_min_ff;
   logic [15:0]        range_max_ff;
   logic [9:0]         gain_ff;
   logic signed [19:0] start_ff;
   logic [23:0]        step_ff;
   logic               csr_write;
   logic [2:0]         csr_index;

   // Captured sample.
   swca_pkg::req_data_type in_ff;

   // Scan state and working registers.
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [swca_pkg::WIS_W-1:0]       wis_ff, wis_in;
   logic [swca_pkg::WS_W-1:0]        ws_ff, ws_in;
   logic signed [WW-1:0]             w_ff, w_in;
   logic signed [PW-1:0]             mul_ff;
   logic [swca_pkg::NUM_W-1:0]       n_ff, n_in;
   logic [swca_pkg::WIS_W-1:0]       mwis_ff, mwis_in;
   logic [swca_pkg::WS_W-1:0]        mws_ff, mws_in;
   logic                             neg_ff, neg_in;
   logic                             zero_ff, zero_in;
   logic [1:0]                       cnt_ff, cnt_in;

   // Result register.
   logic                             rsp_valid_ff, rsp_valid_in;
   swca_pkg::rsp_data_type           rsp_data_ff, rsp_data_in;
   logic                             rsp_load;

   // Shared multiplier.
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] mul_p;

   // Arithmetic helpers.
   logic signed [16:0]   range_diff;
   logic signed [16:0]   span_diff;
   logic [15:0]          digit;
   logic [swca_pkg::NUM_W-1:0] pp_shifted;
   logic signed [24:0]   offset;
   logic signed [25:0]   bearing_sum;
   logic signed [20:0]   bearing_sat;

   // Divider.
   logic                           div_start;
   swca_pkg::div_status_type       div_stat;
   logic [swca_pkg::QUOT_W-1:0]    div_quot;

   // ---------------------------------------------------------------
   // Register port. Writes land in the access phase; reads are
   // combinational from the register file.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= '0;
         range_max_ff <= swca_pkg::RANGE_MAX_RESET;
         gain_ff      <= swca_pkg::GAIN_RESET;
         start_ff     <= '0;
         step_ff      <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            swca_pkg::REG_RANGE_MIN:  range_min_ff <= csr_pwdata[15:0];
            swca_pkg::REG_RANGE_MAX:  range_max_ff <= csr_pwdata[15:0];
            swca_pkg::REG_GAIN:       gain_ff      <= csr_pwdata[9:0];
            swca_pkg::REG_START:      start_ff     <= $signed(csr_pwdata[19:0]);
            swca_pkg::REG_ANGLE_STEP: step_ff      <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         swca_pkg::REG_RANGE_MIN:  csr_prdata = {16'd0, range_min_ff};
         swca_pkg::REG_RANGE_MAX:  csr_prdata = {16'd0, range_max_ff};
         swca_pkg::REG_GAIN:       csr_prdata = {22'd0, gain_ff};
         swca_pkg::REG_START:      csr_prdata = {12'd0, start_ff};
         swca_pkg::REG_ANGLE_STEP: csr_prdata = {8'd0, step_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Shared multiplier. It forms the no-return weight, the index
   // product of every sample and the three 16-bit partial products
   // of |wis| * angle_step for the divider numerator.
   // ---------------------------------------------------------------
   assign range_diff = $signed({1'b0, in_ff.range_mm}) - $signed({1'b0, range_min_ff});
   assign span_diff  = $signed({1'b0, range_max_ff}) - $signed({1'b0, range_min_ff});

   always_comb begin
      case (cnt_ff)
         2'd0:    digit = mwis_ff[15:0];
         2'd1:    digit = mwis_ff[31:16];
         2'd2:    digit = mwis_ff[47:32];
         default: digit = '0;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_WGT) begin
         mul_a = AW'(span_diff);
         mul_b = $signed({15'd0, gain_ff});
      end else if (state_ff == ST_PROD) begin
         mul_a = w_ff;
         mul_b = $signed(BW'(idx_ff));
      end else if (state_ff == ST_PP) begin
         mul_a = $signed(AW'(digit));
         mul_b = $signed({1'b0, step_ff});
      end
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      mul_ff <= mul_p;
   end

   // The partial product computed in the previous cycle carries weight
   // 2^(16*(cnt-1)).
   always_comb begin
      case (cnt_ff)
         2'd1:    pp_shifted = swca_pkg::NUM_W'(mul_ff[39:0]);
         2'd2:    pp_shifted = swca_pkg::NUM_W'(mul_ff[39:0]) << 16;
         2'd3:    pp_shifted = swca_pkg::NUM_W'(mul_ff[39:0]) << 32;
         default: pp_shifted = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Bearing: signed offset plus start angle plus the joint angle of
   // the last sample, clamped to +/- 1000000.
   // ---------------------------------------------------------------
   assign offset = neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
   assign bearing_sum = 26'(offset) + 26'(start_ff) + 26'(in_ff.joint_angle);

   always_comb begin
      if (bearing_sum > swca_pkg::SUM_LIMIT) begin
         bearing_sat = swca_pkg::BEARING_MAX;
      end else if (bearing_sum < -swca_pkg::SUM_LIMIT) begin
         bearing_sat = swca_pkg::BEARING_MIN;
      end else begin
         bearing_sat = bearing_sum[20:0];
      end
   end

   // ---------------------------------------------------------------
   // Sequencer and datapath next values.
   // ---------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign div_start = (state_ff == ST_DGO);
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      wis_in   = wis_ff;
      ws_in    = ws_ff;
      w_in     = w_ff;
      n_in     = n_ff;
      mwis_in  = mwis_ff;
      mws_in   = mws_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_WGT;
            end
         end
         ST_WGT: begin
            // Finite sample: (range - min) in Q.8; no return: span times gain.
            if (in_ff.has_return) begin
               w_in = WW'($signed({range_diff, 8'd0}));
            end else begin
               w_in = mul_p[WW-1:0];
            end
            state_in = ST_PROD;
         end
         ST_PROD: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            wis_in = wis_ff + mul_ff[swca_pkg::WIS_W-1:0];
            ws_in  = ws_ff + swca_pkg::WS_W'(w_ff);
            if (idx_ff != IDX_W'(MAX_SAMPLES - 1)) begin
               idx_in = idx_ff + 1'b1;
            end
            state_in = in_ff.last_sample ? ST_MAG : ST_IDLE;
         end
         ST_MAG: begin
            mwis_in = wis_ff[swca_pkg::WIS_W-1] ? (~wis_ff + 1'b1) : wis_ff;
            mws_in  = ws_ff[swca_pkg::WS_W-1] ? (~ws_ff + 1'b1) : ws_ff;
            neg_in  = wis_ff[swca_pkg::WIS_W-1] ^ ws_ff[swca_pkg::WS_W-1];
            zero_in = (ws_ff == '0);
            n_in    = '0;
            cnt_in  = '0;
            // The scan is closed: clear for the next one.
            idx_in  = '0;
            wis_in  = '0;
            ws_in   = '0;
            state_in = (ws_ff == '0) ? ST_OUT : ST_PP;
         end
         ST_PP: begin
            n_in   = n_ff + pp_shifted;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_DGO;
            end
         end
         ST_DGO: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.zero_weight = zero_ff;
         rsp_data_in.bearing     = zero_ff ? '0 : bearing_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         wis_ff       <= '0;
         ws_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         wis_ff       <= wis_in;
         ws_ff        <= ws_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         in_ff <= req_data;
      end
      w_ff        <= w_in;
      n_ff        <= n_in;
      mwis_ff     <= mwis_in;
      mws_ff      <= mws_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   swca_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (n_ff),
      .den   ({mws_ff, 8'd0}),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SWCA_ASSERT_NOW(a_zero_bearing, clock, reset,
      rsp_valid_ff && rsp_data_ff.zero_weight, rsp_data_ff.bearing == '0)
   `SWCA_ASSERT_NOW(a_bearing_range, clock, reset, rsp_valid_ff,
      rsp_data_ff.bearing <= swca_pkg::BEARING_MAX && rsp_data_ff.bearing >= swca_pkg::BEARING_MIN)
   `SWCA_ASSERT_NOW(a_div_done_state, clock, reset, div_stat.done, state_ff == ST_DIV)
   `SWCA_ASSERT_NOW(a_idle_div_quiet, clock, reset, state_ff == ST_IDLE, !div_stat.busy)
   `SWCA_ASSERT_NEXT(a_accept_weight, clock, reset, req_valid && !req_stall, state_ff == ST_WGT)

endmodule

`default_nettype wire
